// File: hw/rtl/u2a_pkg.sv
`default_nettype none
package u2a_pkg;

    localparam int VALUE_BITS = 32;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int CNT_W      = 6;
    localparam int IDX_W      = $clog2(VALUE_BITS);
    localparam int RADIX_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int STEP_W     = $clog2(VALUE_BITS);

    localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX = 5'd16;

    localparam logic [CHAR_W-1:0] ZERO_CHAR = 8'h30;

    localparam logic [RADIX_W-1:0]    BASE_RESET = 5'd10;
    localparam logic [CFG_DATA_W-1:0] CHARS_LOW_RESET  = 64'h3736353433323130;
    localparam logic [CFG_DATA_W-1:0] CHARS_HIGH_RESET = 64'h6665646362613938;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH = 2'd2;

    typedef struct packed {
        logic load;
        logic div_step;
        logic store;
        logic rd;
        logic k_inc;
    } t_cmd;

    typedef struct packed {
        logic val_zero;
        logic step_done;
        logic quot_zero;
        logic cnt_full;
        logic k_last;
    } t_status;

endpackage
`default_nettype wire

// File: hw/rtl/u2a_ctrl.sv
`default_nettype none
module u2a_ctrl
    import u2a_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    input  wire t_status i_status,
    output t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_STORE = 5'b00100,
        S_READ  = 5'b01000,
        S_SHOW  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = i_status.val_zero ? S_READ : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.step_done) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (i_status.quot_zero || i_status.cnt_full) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SHOW;
            end
            S_SHOW: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    if (i_status.k_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.k_inc = 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/u2a_dpath.sv
`default_nettype none
module u2a_dpath
    import u2a_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [VALUE_BITS-1:0] i_value,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    output logic [CHAR_W-1:0]          o_character,
    output logic                       o_last,
    output logic [CNT_W-1:0]           o_char_count
);

    logic [RADIX_W-1:0]    r_base;
    logic [CFG_DATA_W-1:0] r_chars_low;
    logic [CFG_DATA_W-1:0] r_chars_high;

    logic [RADIX_W-1:0]    r_radix;
    logic [VALUE_BITS-1:0] r_quot;
    logic [DIGIT_W-1:0]    r_rem;
    logic [STEP_W-1:0]     r_step;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      r_k;
    logic                  r_zero;
    logic [DIGIT_W-1:0]    r_rd_digit;

    logic [DIGIT_W-1:0] r_store [VALUE_BITS];

    logic [RADIX_W-1:0]    eff_radix;
    logic [RADIX_W-1:0]    trial;
    logic                  ge;
    logic [RADIX_W-1:0]    diff;
    logic [CNT_W-1:0]      rd_pos;
    logic [CFG_DATA_W-1:0] word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= BASE_RESET;
            r_chars_low  <= CHARS_LOW_RESET;
            r_chars_high <= CHARS_HIGH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BASE_SIZE:  r_base       <= i_cfg_data[RADIX_W-1:0];
                REG_CHARS_LOW:  r_chars_low  <= i_cfg_data;
                REG_CHARS_HIGH: r_chars_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_base < MIN_RADIX) begin
            eff_radix = MIN_RADIX;
        end else if (r_base > MAX_RADIX) begin
            eff_radix = MAX_RADIX;
        end else begin
            eff_radix = r_base;
        end
    end

    // one restoring division step per cycle
    assign trial = {r_rem, r_quot[VALUE_BITS-1]};
    assign ge    = (trial >= r_radix);
    assign diff  = trial - r_radix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_k    <= '0;
            r_quot <= '0;
            r_step <= '0;
            r_zero <= 1'b0;
        end else if (i_cmd.load) begin
            r_quot <= i_value;
            r_step <= '0;
            r_k    <= '0;
            r_zero <= (i_value == '0);
            r_cnt  <= (i_value == '0) ? CNT_W'(1) : '0;
        end else if (i_cmd.div_step) begin
            r_quot <= {r_quot[VALUE_BITS-2:0], ge};
            r_step <= r_step + STEP_W'(1);
        end else if (i_cmd.store) begin
            r_cnt  <= r_cnt + CNT_W'(1);
            r_step <= '0;
        end else if (i_cmd.k_inc) begin
            r_k <= r_k + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_radix <= eff_radix;
            r_rem   <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        end else if (i_cmd.store) begin
            r_rem <= '0;
        end
    end

    assign rd_pos = r_cnt - CNT_W'(1) - r_k;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_store[r_cnt[IDX_W-1:0]] <= r_rem;
        end
        if (i_cmd.rd) begin
            r_rd_digit <= r_store[rd_pos[IDX_W-1:0]];
        end
    end

    assign word = r_rd_digit[DIGIT_W-1] ? r_chars_high : r_chars_low;

    always_comb begin
        if (r_zero) begin
            o_character = ZERO_CHAR;
        end else begin
            o_character = word[{r_rd_digit[DIGIT_W-2:0], 3'b000} +: CHAR_W];
        end
    end

    assign o_last       = ((r_k + CNT_W'(1)) == r_cnt);
    assign o_char_count = r_cnt;

    assign o_status.val_zero  = (i_value == '0);
    assign o_status.step_done = (r_step == STEP_W'(VALUE_BITS - 1));
    assign o_status.quot_zero = (r_quot == '0);
    assign o_status.cnt_full  = (r_cnt == CNT_W'(VALUE_BITS - 1));
    assign o_status.k_last    = o_last;

endmodule
`default_nettype wire

// File: hw/rtl/unsigned_to_ascii_any_base.sv
// each digit takes a division step for every value bit, then a store; each character takes a read and a show state
// a zero value gives its single character through the read and show states after it is taken
// one value at a time: worst case 32 digits in base 2
// the bit-serial divider sets the rate; a stalled output holds the block
// synchronous active-low reset restores the default radix and digit table
// the digit store is not cleared by reset
`default_nettype none
module unsigned_to_ascii_any_base
    import u2a_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [VALUE_BITS-1:0] i_value,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [CHAR_W-1:0]          o_character,
    output logic                       o_last,
    output logic [CNT_W-1:0]           o_char_count
);

    t_cmd    cmd;
    t_status status;

    u2a_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    u2a_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_value      (i_value),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_character  (o_character),
        .o_last       (o_last),
        .o_char_count (o_char_count)
    );

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import u2a_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int IDLE_LIMIT   = 20000;
    localparam int RANDOM_ITEMS = 260;
    localparam int TAIL_START   = 225;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic [CNT_W-1:0]  count;
    } t_digit_out;

    typedef struct {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        string                 text;
    } t_plan_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid    = 1'b0;
    logic [VALUE_BITS-1:0] i_value    = '0;
    logic                  i_stall    = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic [CHAR_W-1:0]     o_character;
    logic                  o_last;
    logic [CNT_W-1:0]      o_char_count;

    logic [RADIX_W-1:0]    cur_base  = BASE_RESET;
    logic [CFG_DATA_W-1:0] cur_low   = CHARS_LOW_RESET;
    logic [CFG_DATA_W-1:0] cur_high  = CHARS_HIGH_RESET;

    t_digit_out pending_chars[$];
    string      typed_text_q[$];
    t_plan_row  plan_q[$];

    int  errors        = 0;
    int  values_taken  = 0;
    int  chars_checked = 0;
    int  cfg_writes    = 0;
    int  items_sent    = 0;
    bit  quiet_tail    = 1'b0;

    unsigned_to_ascii_any_base dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_character  (o_character),
        .o_last       (o_last),
        .o_char_count (o_char_count)
    );

    always #5ns i_clk = ~i_clk;

    // expected characters of one value, most significant first
    function automatic void predict_digits(logic [VALUE_BITS-1:0] v);
        logic [RADIX_W-1:0] r;
        int unsigned        q;
        logic [3:0]         digs[32];
        int                 n;
        logic [3:0]         d;
        logic [CHAR_W-1:0]  ch;
        r = cur_base;
        if (r < MIN_RADIX) r = MIN_RADIX;
        if (r > MAX_RADIX) r = MAX_RADIX;
        if (v == 0) begin
            pending_chars.push_back('{ZERO_CHAR, 1'b1, CNT_W'(1)});
            return;
        end
        q = v;
        n = 0;
        while (q != 0 && n < VALUE_BITS) begin
            digs[n] = 4'(q % r);
            q = q / r;
            n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
            d  = digs[k];
            ch = d[3] ? cur_high[{d[2:0], 3'b000} +: 8] : cur_low[{d[2:0], 3'b000} +: 8];
            pending_chars.push_back('{ch, k == 0, CNT_W'(n)});
        end
    endfunction

    function automatic void push_typed(string txt);
        for (int k = 0; k < txt.len(); k++)
            pending_chars.push_back('{txt[k], k == txt.len() - 1, CNT_W'(txt.len())});
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        plan_q.push_back('{1'b1, idx, data, ""});
    endfunction

    function automatic void add_val(logic [VALUE_BITS-1:0] v, string txt);
        plan_q.push_back('{1'b0, REG_BASE_SIZE, CFG_DATA_W'(v), txt});
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_BASE_SIZE:  cur_base = data[RADIX_W-1:0];
            REG_CHARS_LOW:  cur_low  = data;
            REG_CHARS_HIGH: cur_high = data;
            default: ;
        endcase
        cfg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // offer one item, hold it until taken
    task automatic send_value(logic [VALUE_BITS-1:0] v, string txt);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        typed_text_q.push_back(txt);
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending_chars.size() != 0 || typed_text_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // scoreboard
    always @(posedge i_clk) begin
        t_digit_out want;
        string      txt;
        if (i_rst_n && i_valid && o_stall === 1'b0) begin
            txt = typed_text_q.pop_front();
            if (txt.len() != 0) push_typed(txt);
            else predict_digits(i_value);
            values_taken++;
        end
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            chars_checked++;
            if (pending_chars.size() == 0) begin
                errors++;
                $display("%0t: expected no item got char %h last %b count %0d", $realtime,
                         o_character, o_last, o_char_count);
            end else begin
                want = pending_chars.pop_front();
                if (o_character !== want.ch || o_last !== want.last ||
                        o_char_count !== want.count) begin
                    errors++;
                    $display("%0t: char/last/count expected %h/%b/%0d got %h/%b/%0d",
                             $realtime, want.ch, want.last, want.count,
                             o_character, o_last, o_char_count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        int idle_cycles;
        if ((i_valid && o_stall === 1'b0) || (o_valid === 1'b1 && !i_stall) || i_cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("unsigned_to_ascii_any_base verification failed");
            $finish;
        end
    end

    // output side
    initial begin
        bit held_long;
        held_long = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_long && values_taken >= 60) begin
                held_long = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        logic [RADIX_W-1:0]    b;
        logic [CFG_DATA_W-1:0] d;
        logic [VALUE_BITS-1:0] v;
        int                    phase_len;

        add_val(32'd0, "0");
        add_val(32'd7, "7");
        add_val(32'd10, "10");
        add_val(32'hFFFF_FFFF, "4294967295");
        add_val(32'h8000_0000, "2147483648");
        add_cfg(REG_BASE_SIZE, 64'd16);
        add_val(32'hFFFF_FFFF, "ffffffff");
        add_val(32'hDEAD_BEEF, "deadbeef");
        add_val(32'd0, "0");
        add_cfg(REG_BASE_SIZE, 64'd2);
        add_val(32'd5, "101");
        add_val(32'hFFFF_FFFF, "");
        add_val(32'h8000_0000, "");
        // radix below two clamps up, above sixteen clamps down
        add_cfg(REG_BASE_SIZE, 64'd0);
        add_val(32'd6, "110");
        add_cfg(REG_BASE_SIZE, 64'd1);
        add_val(32'd1, "1");
        add_cfg(REG_BASE_SIZE, 64'd31);
        add_val(32'd255, "ff");
        add_cfg(REG_BASE_SIZE, 64'd17);
        add_val(32'hABC, "abc");
        add_cfg(REG_BASE_SIZE, 64'd3);
        add_val(32'd12345, "");
        // zero ignores the digit table
        add_cfg(REG_CHARS_LOW, 64'd0);
        add_cfg(REG_CHARS_HIGH, '1);
        add_cfg(REG_BASE_SIZE, 64'd16);
        add_val(32'h89AB_CDEF, "");
        add_val(32'd0, "0");
        // write to an unused index is dropped
        add_cfg(REG_SPARE, 64'h5555_5555_5555_5555);
        add_val(32'h0123_4567, "");
        add_cfg(REG_CHARS_LOW, '1);
        add_cfg(REG_CHARS_HIGH, 64'd0);
        add_cfg(REG_BASE_SIZE, 64'hFFFF_FFFF_FFFF_FFE4);
        add_val(32'd1000, "");

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan_q[n]) begin
            if (plan_q[n].is_cfg) begin
                drain();
                cfg_write(plan_q[n].idx, plan_q[n].data);
            end else begin
                send_value(plan_q[n].data[VALUE_BITS-1:0], plan_q[n].text);
            end
        end

        while (items_sent < RANDOM_ITEMS) begin
            if (items_sent >= TAIL_START) quiet_tail = 1'b1;
            drain();
            case ($urandom_range(0, 3))
                0: b = MIN_RADIX;
                1: b = MAX_RADIX;
                default: b = RADIX_W'($urandom_range(0, 31));
            endcase
            d = {$urandom, $urandom};
            d[RADIX_W-1:0] = b;
            cfg_write(REG_BASE_SIZE, d);
            case ($urandom_range(0, 3))
                0: begin
                    cfg_write(REG_CHARS_LOW, CHARS_LOW_RESET);
                    cfg_write(REG_CHARS_HIGH, CHARS_HIGH_RESET);
                end
                1: begin
                    cfg_write(REG_CHARS_LOW, {$urandom, $urandom});
                    cfg_write(REG_CHARS_HIGH, {$urandom, $urandom});
                end
                2: cfg_write(CFG_IDX_W'($urandom_range(1, 3)), {$urandom, $urandom});
                default: ;
            endcase
            phase_len = $urandom_range(15, 35);
            for (int k = 0; k < phase_len && items_sent < RANDOM_ITEMS; k++) begin
                case ($urandom_range(0, 9))
                    0: v = '0;
                    1: v = '1;
                    2: v = VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1);
                    3, 4: v = VALUE_BITS'($urandom_range(0, 300));
                    default: v = $urandom >> $urandom_range(0, VALUE_BITS - 1);
                endcase
                send_value(v, "");
                items_sent++;
            end
        end

        drain();
        repeat (50) @(posedge i_clk);
        $display("converted %0d values into %0d characters", values_taken, chars_checked);
        $display("across %0d register writes, radix 0 to 31, reset and random digit tables",
                 cfg_writes);
        if (errors == 0)
            $display("unsigned_to_ascii_any_base verification clean");
        else
            $display("unsigned_to_ascii_any_base verification failed");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/u2a_pkg.sv
hw/rtl/u2a_ctrl.sv
hw/rtl/u2a_dpath.sv
hw/rtl/unsigned_to_ascii_any_base.sv
tb/sv/tb_top.sv
